// ----- rtl/assert_macros.svh -----
// Assertion helpers included by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ----- rtl/tmb_pkg.sv -----
package tmb_pkg;

	// Geometry of the block
	localparam int PIXEL_COUNT = 1024;
	localparam int CHANNELS    = 3;
	localparam int COUNT_BITS  = 8;

	// Fixed field widths
	localparam int PIX_BITS    = 10;
	localparam int CH_BITS     = 2;
	localparam int SAMPLE_BITS = 8;

	// Derived store sizes
	localparam int LOC_COUNT     = PIXEL_COUNT * CHANNELS;
	localparam int LOC_BITS      = (LOC_COUNT > 1) ? $clog2(LOC_COUNT) : 1;
	localparam int BIN_DEPTH     = LOC_COUNT * (2 ** SAMPLE_BITS);
	localparam int BIN_ADDR_BITS = LOC_BITS + SAMPLE_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_UPDATE
	} tmb_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic fetch;
		logic update;
	} tmb_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_last;
	} tmb_stat_t;

endpackage

// ----- rtl/tmb_ram.sv -----
// Single-port RAM, registered read
module tmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

// ----- rtl/tmb_ctrl.sv -----
// Sequencer: clearing pass, then accept / fetch / update per item
module tmb_ctrl import tmb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  tmb_stat_t stat,
	output tmb_cmd_t  cmd,
	output logic      busy
);

	tmb_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ----- rtl/tmb_datapath.sv -----
// Histogram and mode stores, update arithmetic and result registers
module tmb_datapath import tmb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tmb_cmd_t               cmd,
	output tmb_stat_t              stat,
	input  logic [PIX_BITS-1:0]    pixel_index,
	input  logic [CH_BITS-1:0]     channel,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   done,
	output logic [PIX_BITS-1:0]    out_pixel_index,
	output logic [CH_BITS-1:0]     out_channel,
	output logic [SAMPLE_BITS-1:0] mode_value
);

	logic [BIN_ADDR_BITS-1:0] clr_q;
	logic [PIX_BITS-1:0]      pix_q;
	logic [CH_BITS-1:0]       ch_q;
	logic [SAMPLE_BITS-1:0]   val_q;
	logic [LOC_BITS-1:0]      loc_q;
	logic                     ok_q;
	logic [COUNT_BITS-1:0]    cnt_q;
	logic [SAMPLE_BITS-1:0]   mode_q;
	logic                     done_q;
	logic [PIX_BITS-1:0]      out_pix_q;
	logic [CH_BITS-1:0]       out_ch_q;
	logic [SAMPLE_BITS-1:0]   out_mode_q;

	logic [LOC_BITS-1:0]      loc_in;
	logic                     ok_in;
	logic                     clr_in_loc;
	logic [COUNT_BITS-1:0]    cnt_inc;
	logic [COUNT_BITS-1:0]    mcnt;
	logic                     take;
	logic [SAMPLE_BITS-1:0]   new_mode;

	logic                     bin_en, bin_we;
	logic [BIN_ADDR_BITS-1:0] bin_addr;
	logic [COUNT_BITS-1:0]    bin_wdata, bin_rdata;
	logic                     mode_en, mode_we;
	logic [LOC_BITS-1:0]      mode_addr;
	logic [SAMPLE_BITS-1:0]   mode_wdata, mode_rdata;

	// Location of the incoming item and its range check
	assign loc_in = LOC_BITS'(LOC_BITS'(pixel_index) * LOC_BITS'(CHANNELS)
		+ LOC_BITS'(channel));
	assign ok_in  = (32'(pixel_index) < 32'(PIXEL_COUNT)) && (32'(channel) < 32'(CHANNELS));

	// Clearing pass counter
	assign clr_in_loc      = 32'(clr_q) < 32'(LOC_COUNT);
	assign stat.clear_last = clr_q == BIN_ADDR_BITS'(BIN_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && !stat.clear_last) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Update arithmetic: saturating increment, then compare with the mode's bin
	assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign mcnt     = (mode_q == val_q) ? cnt_inc : bin_rdata;
	assign take     = mcnt < cnt_inc;
	assign new_mode = take ? val_q : mode_q;

	// Memory port steering
	always_comb begin
		bin_en     = 1'b0;
		bin_we     = 1'b0;
		bin_addr   = clr_q;
		bin_wdata  = '0;
		mode_en    = 1'b0;
		mode_we    = 1'b0;
		mode_addr  = clr_q[LOC_BITS-1:0];
		mode_wdata = '0;
		if (cmd.clr_step) begin
			bin_en  = 1'b1;
			bin_we  = 1'b1;
			mode_en = clr_in_loc;
			mode_we = clr_in_loc;
		end else if (cmd.accept) begin
			bin_en    = ok_in;
			bin_addr  = {loc_in, sample};
			mode_en   = ok_in;
			mode_addr = loc_in;
		end else if (cmd.fetch) begin
			bin_en   = ok_q;
			bin_addr = {loc_q, mode_rdata};
		end else if (cmd.update) begin
			bin_en     = ok_q;
			bin_we     = ok_q;
			bin_addr   = {loc_q, val_q};
			bin_wdata  = cnt_inc;
			mode_en    = ok_q && take;
			mode_we    = ok_q && take;
			mode_addr  = loc_q;
			mode_wdata = val_q;
		end
	end

	tmb_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (BIN_DEPTH)
	) u_bin_ram (
		.clk   (clk),
		.en    (bin_en),
		.we    (bin_we),
		.addr  (bin_addr),
		.wdata (bin_wdata),
		.rdata (bin_rdata)
	);

	tmb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (LOC_COUNT)
	) u_mode_ram (
		.clk   (clk),
		.en    (mode_en),
		.we    (mode_we),
		.addr  (mode_addr),
		.wdata (mode_wdata),
		.rdata (mode_rdata)
	);

	// Item capture and fetched values
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q <= pixel_index;
			ch_q  <= channel;
			val_q <= sample;
			loc_q <= loc_in;
			ok_q  <= ok_in;
		end
		if (cmd.fetch) begin
			cnt_q  <= bin_rdata;
			mode_q <= mode_rdata;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_pix_q  <= pix_q;
			out_ch_q   <= ch_q;
			out_mode_q <= ok_q ? new_mode : '0;
		end
	end

	assign done            = done_q;
	assign out_pixel_index = out_pix_q;
	assign out_channel     = out_ch_q;
	assign mode_value      = out_mode_q;

endmodule

// ----- rtl/temporal_mode_background.sv -----
// Per-pixel temporal mode background estimator. Each item is one sample (pixel,
// channel, 8-bit value); the block bumps that value's bin in the location's
// 256-bin histogram and returns the location's most frequent value. An item is
// taken when start is high and busy is low; its result is shown for one cycle
// with done high, registered from the update state that follows the fetch state,
// and cannot be stalled. No new item is taken until the last one is through, as
// the single-port counter memory serves the sample-bin read, the mode-bin read
// and the write-back in turn. Out-of-range locations change nothing and return
// mode 0. After reset a clearing pass over all BIN_DEPTH counter addresses
// (786432 at the default size) zeroes both stores; busy is high throughout.
module temporal_mode_background import tmb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [PIX_BITS-1:0]    pixel_index,
	input  logic [CH_BITS-1:0]     channel,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   done,
	output logic [PIX_BITS-1:0]    out_pixel_index,
	output logic [CH_BITS-1:0]     out_channel,
	output logic [SAMPLE_BITS-1:0] mode_value
);

	tmb_cmd_t  cmd;
	tmb_stat_t stat;

	tmb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tmb_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.pixel_index     (pixel_index),
		.channel         (channel),
		.sample          (sample),
		.done            (done),
		.out_pixel_index (out_pixel_index),
		.out_channel     (out_channel),
		.mode_value      (mode_value)
	);

endmodule

// ----- rtl/tmb_checker.sv -----
`include "assert_macros.svh"

// Port-level checks of the estimator
module tmb_checker import tmb_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic [PIX_BITS-1:0]    pixel_index,
	input logic [CH_BITS-1:0]     channel,
	input logic [SAMPLE_BITS-1:0] sample,
	input logic                   done,
	input logic [PIX_BITS-1:0]    out_pixel_index,
	input logic [CH_BITS-1:0]     out_channel,
	input logic [SAMPLE_BITS-1:0] mode_value
);

	logic accept;
	assign accept = start && !busy;

	// An accepted item keeps the block busy next cycle
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)

	// A result follows its accepted item through the fetch and update states
	`ASSERT_IMPLY(a_done_latency, clk, arst_n, done, $past(accept, 3))

	// The result echoes the accepted location
	`ASSERT_IMPLY(a_done_echo, clk, arst_n, done, (out_pixel_index == $past(pixel_index, 3)) && (out_channel == $past(channel, 3)))

	// Results never come on consecutive cycles
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

	// An invalid channel returns mode zero
	`ASSERT_IMPLY(a_bad_channel, clk, arst_n, done && (32'(out_channel) >= 32'(CHANNELS)), mode_value == '0)

endmodule

bind temporal_mode_background tmb_checker u_tmb_checker (.*);

// ----- dv/mode_checker.sv -----
`timescale 1ns / 100ps

// Watches the item and result channels, predicts the background mode of every
// accepted item and compares each result against the oldest prediction.
module mode_checker import tmb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [PIX_BITS-1:0]    pixel_index,
	input  logic [CH_BITS-1:0]     channel,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   done,
	input  logic [PIX_BITS-1:0]    out_pixel_index,
	input  logic [CH_BITS-1:0]     out_channel,
	input  logic [SAMPLE_BITS-1:0] mode_value,
	output int                     mismatches,
	output int                     pending
);

	typedef struct packed {
		logic [PIX_BITS-1:0]    pix;
		logic [CH_BITS-1:0]     ch;
		logic [SAMPLE_BITS-1:0] mode;
	} mode_result_t;

	// Shadow histograms and modes, one entry per pixel/channel location
	logic [COUNT_BITS-1:0]  hist [BIN_DEPTH];
	logic [SAMPLE_BITS-1:0] modes [LOC_COUNT];
	mode_result_t           mode_q [$];

	always @(posedge clk or negedge arst_n) begin
		int unsigned            loc;
		int unsigned            base;
		logic [COUNT_BITS-1:0]  cnt;
		logic [SAMPLE_BITS-1:0] m;
		mode_result_t           got;
		mode_result_t           want;
		if (!arst_n) begin
			foreach (hist[i]) hist[i] = '0;
			foreach (modes[i]) modes[i] = '0;
			mode_q.delete();
			mismatches = 0;
		end else begin
			// check a result against the oldest prediction
			if (done) begin
				got = '{out_pixel_index, out_channel, mode_value};
				if (mode_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result pix=%0d ch=%0d mode=%0d",
							$time, got.pix, got.ch, got.mode);
				end else begin
					want = mode_q.pop_front();
					if (got.pix != want.pix || got.ch != want.ch || got.mode != want.mode) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp pix=%0d ch=%0d mode=%0d, got pix=%0d ch=%0d mode=%0d",
								$time, want.pix, want.ch, want.mode, got.pix, got.ch, got.mode);
					end
				end
			end

			// predict the result of an accepted item
			if (start && !busy) begin
				m = '0;
				if (int'(pixel_index) < PIXEL_COUNT && int'(channel) < CHANNELS) begin
					loc  = int'(pixel_index) * CHANNELS + int'(channel);
					base = loc << SAMPLE_BITS;
					cnt  = hist[base + sample];
					// counters stick at full scale
					if (cnt != COUNT_MAX)
						cnt++;
					hist[base + sample] = cnt;
					// sample takes over only on a strictly higher count
					m = modes[loc];
					if (hist[base + m] < cnt) begin
						m = sample;
						modes[loc] = sample;
					end
				end
				want   = '{pixel_index, channel, m};
				mode_q = {mode_q, want};
			end
		end
		pending = mode_q.size();
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import tmb_pkg::*;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   start       = 1'b0;
	logic [PIX_BITS-1:0]    pixel_index = '0;
	logic [CH_BITS-1:0]     channel     = '0;
	logic [SAMPLE_BITS-1:0] sample      = '0;
	logic                   busy;
	logic                   done;
	logic [PIX_BITS-1:0]    out_pixel_index;
	logic [CH_BITS-1:0]     out_channel;
	logic [SAMPLE_BITS-1:0] mode_value;

	int fails;
	int outstanding;
	int idle_pct = 0;

	// Locations hammered by the random part, each with a small set of values
	logic [PIX_BITS-1:0]    hot_pix [8];
	logic [CH_BITS-1:0]     hot_ch  [8];
	logic [SAMPLE_BITS-1:0] hot_val [8][3];

	temporal_mode_background dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.pixel_index     (pixel_index),
		.channel         (channel),
		.sample          (sample),
		.done            (done),
		.out_pixel_index (out_pixel_index),
		.out_channel     (out_channel),
		.mode_value      (mode_value)
	);

	mode_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.pixel_index     (pixel_index),
		.channel         (channel),
		.sample          (sample),
		.done            (done),
		.out_pixel_index (out_pixel_index),
		.out_channel     (out_channel),
		.mode_value      (mode_value),
		.mismatches      (fails),
		.pending         (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop; covers the clearing pass after reset several times over
	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

	// Offer one item from a falling edge, hold until taken, return at a falling edge
	task automatic send_item(input logic [PIX_BITS-1:0] p, input logic [CH_BITS-1:0] c,
		input logic [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		pixel_index <= p;
		channel     <= c;
		sample      <= s;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Mostly repeat hits on a few locations so modes compete, plus noise
	task automatic run_random(input int target);
		int in_range;
		int pick;
		int h;
		in_range = 0;
		for (int i = 0; i < 8; i++) begin
			hot_pix[i] = PIX_BITS'($urandom_range(PIXEL_COUNT - 1));
			hot_ch[i]  = CH_BITS'($urandom_range(CHANNELS - 1));
			for (int j = 0; j < 3; j++)
				hot_val[i][j] = SAMPLE_BITS'($urandom_range(255));
		end
		while (in_range < target) begin
			pick = $urandom_range(99);
			h    = $urandom_range(7);
			if (pick < 70)
				send_item(hot_pix[h], hot_ch[h], hot_val[h][$urandom_range(2)]);
			else if (pick < 90)
				send_item(PIX_BITS'($urandom_range(PIXEL_COUNT - 1)),
					CH_BITS'($urandom_range(CHANNELS - 1)),
					SAMPLE_BITS'($urandom_range(255)));
			else
				send_item(PIX_BITS'($urandom_range(PIXEL_COUNT - 1)), 2'd3,
					SAMPLE_BITS'($urandom_range(255)));
			if (pick < 90)
				in_range++;
		end
	endtask

	initial begin
		logic [PIX_BITS-1:0]    sat_pix;
		logic [CH_BITS-1:0]     sat_ch;
		logic [SAMPLE_BITS-1:0] sat_a;
		logic [SAMPLE_BITS-1:0] sat_b;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, ties, sample equal to mode, bad channel
		idle_pct = 21;
		send_item(10'd0,    2'd0, 8'd0);
		send_item(10'd1023, 2'd2, 8'd255);
		send_item(10'd1023, 2'd2, 8'd0);
		send_item(10'd1023, 2'd2, 8'd0);
		send_item(10'd1023, 2'd3, 8'd170);
		send_item(10'd0,    2'd3, 8'd85);
		send_item(10'd1023, 2'd2, 8'd255);
		send_item(10'd512,  2'd1, 8'd5);
		send_item(10'd512,  2'd1, 8'd7);
		send_item(10'd512,  2'd1, 8'd7);
		send_item(10'd512,  2'd1, 8'd5);
		send_item(10'd512,  2'd1, 8'd5);
		send_item(10'd341,  2'd0, 8'd128);
		send_item(10'd682,  2'd1, 8'd127);
		send_item(10'd0,    2'd0, 8'd0);
		send_item(10'd1023, 2'd3, 8'd255);
		send_item(10'd682,  2'd3, 8'd0);
		run_random(50);

		idle_pct = 60;
		run_random(50);

		// Back to back: drive one bin past full scale, then a rival below it
		idle_pct = 0;
		sat_pix = PIX_BITS'($urandom_range(PIXEL_COUNT - 1));
		sat_ch  = CH_BITS'($urandom_range(CHANNELS - 1));
		sat_a   = SAMPLE_BITS'($urandom_range(255));
		sat_b   = sat_a ^ 8'(1 + $urandom_range(254));
		repeat (257) send_item(sat_pix, sat_ch, sat_a);
		repeat (3) send_item(sat_pix, sat_ch, sat_b);
		send_item(sat_pix, sat_ch, sat_a);
		run_random(50);

		start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
